// ===== rtl/spbpm_pkg.sv =====
package spbpm_pkg;

  localparam int MAX_BARS_DEF       = 128;
  localparam int LOG_TABLE_BITS_DEF = 6;
  localparam int QUEUE_DEPTH        = 4;

  localparam int MAG_W   = 16;
  localparam int LEVEL_W = 13;
  localparam int PIX_W   = 12;
  localparam int TIMER_W = 8;
  localparam int IDX_W   = 7;
  localparam int CFG_W   = 13;
  localparam int CFG_AW  = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 13'd4096;
  localparam logic [12:0]        DB_SCALE   = 13'd6576;

  localparam logic [CFG_AW-1:0] REG_BAR_COUNT   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PLOT_HEIGHT = 3'd1;
  localparam logic [CFG_AW-1:0] REG_HOLD_FRAMES = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DECAY_STEP  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_VIS_THRESH  = 3'd4;

  localparam logic [7:0]         BAR_COUNT_RST   = 8'd80;
  localparam logic [PIX_W-1:0]   PLOT_HEIGHT_RST = 12'd240;
  localparam logic [TIMER_W-1:0] HOLD_FRAMES_RST = 8'd30;
  localparam logic [LEVEL_W-1:0] DECAY_STEP_RST  = 13'd20;
  localparam logic [LEVEL_W-1:0] VIS_THRESH_RST  = 13'd41;

  typedef struct packed {
    logic [7:0]         bar_count;
    logic [PIX_W-1:0]   plot_height;
    logic [TIMER_W-1:0] hold_frames;
    logic [LEVEL_W-1:0] decay_step;
    logic [LEVEL_W-1:0] visible_threshold;
  } cfg_t;

endpackage

// ===== rtl/spbpm_ram.sv =====
module spbpm_ram import spbpm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/spbpm_fifo.sv =====
module spbpm_fifo import spbpm_pkg::*; #(
  parameter int WIDTH = MAG_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (!push && pop) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== rtl/spbpm_front.sv =====
module spbpm_front import spbpm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [MAG_W-1:0] magnitude,
  input  logic             bar_end,
  input  logic             back_busy,
  input  logic             q_full,
  output logic             q_push,
  output logic [MAG_W-1:0] q_data
);

  logic [MAG_W-1:0] running_max;
  logic [MAG_W-1:0] max_next;
  logic             accept;

  assign in_ready = !q_full && !back_busy;
  assign accept   = in_valid && in_ready;
  assign max_next = (magnitude > running_max) ? magnitude : running_max;
  assign q_push   = accept && bar_end;
  assign q_data   = max_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= '0;
    end else if (accept) begin
      running_max <= bar_end ? '0 : max_next;
    end
  end

endmodule

// ===== rtl/spbpm_back.sv =====
module spbpm_back import spbpm_pkg::*; #(
  parameter int MAX_BARS       = MAX_BARS_DEF,
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  logic [MAG_W-1:0]   q_data,
  output logic               q_pop,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   bar_index,
  output logic [LEVEL_W-1:0] level,
  output logic [PIX_W-1:0]   bar_height,
  output logic [PIX_W-1:0]   peak_row,
  output logic               peak_visible
);

  localparam int BW       = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int CW       = $clog2(MAX_BARS + 1);
  localparam int TAB_SIZE = 1 << LOG_TABLE_BITS;
  localparam int ENT_W    = TIMER_W + LEVEL_W;

  typedef logic [LEVEL_W-1:0] tab_t [TAB_SIZE];

  function automatic logic [LEVEL_W-1:0] log_frac(int i);
    logic [63:0] y;
    logic [15:0] bits;
    y    = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
    bits = '0;
    for (int k = 0; k < 14; k++) begin
      y    = (y * y) >> 30;
      bits = bits << 1;
      if (y >= (64'd2 << 30)) begin
        bits = bits | 16'd1;
        y    = y >> 1;
      end
    end
    return LEVEL_W'((bits + 16'd2) >> 2);
  endfunction

  function automatic tab_t build_tab();
    tab_t t;
    for (int i = 0; i < TAB_SIZE; i++) begin
      t[i] = log_frac(i);
    end
    return t;
  endfunction

  localparam tab_t LOG_TAB = build_tab();

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_NORM  = 7'b0000100,
    ST_LOG   = 7'b0001000,
    ST_SCALE = 7'b0010000,
    ST_UPD   = 7'b0100000,
    ST_MUL   = 7'b1000000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [BW-1:0]             clr_addr;
  logic [BW-1:0]             bar_counter;
  logic [BW-1:0]             b_reg;
  logic [MAG_W-1:0]          m_reg;
  logic                      m_zero;
  logic [3:0]                e_reg;
  logic [LOG_TABLE_BITS-1:0] idx_reg;
  logic [16:0]               neg_reg;
  logic [LEVEL_W-1:0]        lvl_reg;
  logic [LEVEL_W-1:0]        pk_reg;

  logic [CW-1:0]             count_eff;
  logic [BW-1:0]             b_sel;
  logic                      b_wrap;
  logic [3:0]                e_comb;
  logic [MAG_W-1:0]          m_norm;
  logic [29:0]               d_prod;
  logic [13:0]               d_val;
  logic [LEVEL_W-1:0]        lvl_comb;
  logic [ENT_W-1:0]          ram_rdata;
  logic [ENT_W-1:0]          ram_wdata;
  logic                      ram_we;
  logic [BW-1:0]             ram_waddr;
  logic [TIMER_W-1:0]        t_old;
  logic [LEVEL_W-1:0]        pk_old;
  logic [TIMER_W-1:0]        t_new;
  logic [LEVEL_W-1:0]        pk_new;
  logic [24:0]               h_prod;
  logic [24:0]               p_prod;
  logic                      out_load;

  always_comb begin
    if (cfg.bar_count == '0) begin
      count_eff = CW'(1);
    end else if (32'(cfg.bar_count) > MAX_BARS) begin
      count_eff = CW'(MAX_BARS);
    end else begin
      count_eff = CW'(cfg.bar_count);
    end
  end

  assign b_sel  = (CW'(bar_counter) >= count_eff) ? '0 : bar_counter;
  assign b_wrap = ((CW + 1)'(b_sel) + (CW + 1)'(1)) >= (CW + 1)'(count_eff);

  always_comb begin
    e_comb = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m_reg[i]) begin
        e_comb = 4'(i);
      end
    end
  end

  assign m_norm   = m_reg << (4'd15 - e_comb);
  assign d_prod   = 30'(neg_reg) * 30'(DB_SCALE) + 30'd32768;
  assign d_val    = d_prod[29:16];
  assign lvl_comb = (m_zero || d_val >= 14'(LEVEL_FULL)) ? '0 : LEVEL_FULL - LEVEL_W'(d_val);

  assign t_old  = ram_rdata[ENT_W-1:LEVEL_W];
  assign pk_old = ram_rdata[LEVEL_W-1:0];

  always_comb begin
    t_new  = t_old;
    pk_new = pk_old;
    if (lvl_reg > pk_old) begin
      pk_new = lvl_reg;
      t_new  = cfg.hold_frames;
    end else if (t_old != '0) begin
      t_new = t_old - TIMER_W'(1);
    end else begin
      pk_new = (pk_old > cfg.decay_step) ? pk_old - cfg.decay_step : '0;
    end
  end

  assign ram_we    = (state == ST_CLEAR) || (state == ST_UPD);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : b_reg;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : {t_new, pk_new};

  spbpm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BARS)
  ) u_peak_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (b_reg),
    .rdata (ram_rdata)
  );

  assign h_prod   = 25'(lvl_reg) * 25'(cfg.plot_height);
  assign p_prod   = 25'(pk_reg) * 25'(cfg.plot_height);
  assign out_load = (state == ST_MUL) && (!out_valid || out_ready);
  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign busy     = (state == ST_CLEAR);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: state_next = (clr_addr == BW'(MAX_BARS - 1)) ? ST_IDLE : ST_CLEAR;
      ST_IDLE:  state_next = q_empty ? ST_IDLE : ST_NORM;
      ST_NORM:  state_next = ST_LOG;
      ST_LOG:   state_next = ST_SCALE;
      ST_SCALE: state_next = ST_UPD;
      ST_UPD:   state_next = ST_MUL;
      ST_MUL:   state_next = out_load ? ST_IDLE : ST_MUL;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      bar_counter <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + BW'(1);
      end
      if (q_pop) begin
        bar_counter <= b_wrap ? '0 : b_sel + BW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_reg <= q_data;
      b_reg <= b_sel;
    end
    if (state == ST_NORM) begin
      m_zero  <= (m_reg == '0);
      e_reg   <= e_comb;
      idx_reg <= m_norm[MAG_W-2 -: LOG_TABLE_BITS];
    end
    if (state == ST_LOG) begin
      neg_reg <= {5'd16 - 5'(e_reg), 12'd0} - 17'(LOG_TAB[idx_reg]);
    end
    if (state == ST_SCALE) begin
      lvl_reg <= lvl_comb;
    end
    if (state == ST_UPD) begin
      pk_reg <= pk_new;
    end
    if (out_load) begin
      bar_index    <= IDX_W'(b_reg);
      level        <= lvl_reg;
      bar_height   <= h_prod[23:12];
      peak_row     <= cfg.plot_height - p_prod[23:12];
      peak_visible <= (pk_reg > cfg.visible_threshold);
    end
  end

  a_bar_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_NORM) |-> (CW'(b_reg) < count_eff))
    else $error("bar index beyond bar count");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level <= LEVEL_FULL))
    else $error("level above full scale");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && !out_valid) |=> out_valid)
    else $error("result not loaded");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == ST_NORM))
    else $error("popped item not processed");

endmodule

// ===== rtl/spectrum_bar_peak_meter_core.sv =====
// Peak-hold bar meter over a stream of spectrum bins.
// Input channel (in_valid/in_ready): one unsigned Q0.16 magnitude per item;
// bar_end marks the last bin of a bar. Bins are taken one per cycle while in_ready is high.
// Output channel (out_valid/out_ready): one item per bar with the bar index,
// Q1.12 dB level, bar height, peak row and peak visibility.
// Each bar_end pushes the bar maximum into a 4-entry queue; the back end
// takes one bar at a time and finishes it before popping the next (pop,
// normalize, log table, dB scale, peak-store update, pixel multiply).
// Bins keep flowing while bars queue; in_ready drops when the queue is
// full or while the peak/timer store is cleared after reset.
// If the receiver stalls, the finished result waits in the output register
// and the back end holds its next result; the queue then fills and in_ready
// falls.
// Reset loads the register defaults, clears the running max and bar counter,
// and sweeps every entry of the peak/timer store to zero, during which
// in_ready is low. Register writes (cfg_we) take effect at once.
module spectrum_bar_peak_meter_core import spbpm_pkg::*; #(
  parameter int MAX_BARS       = MAX_BARS_DEF,
  parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MAG_W-1:0]   magnitude,
  input  logic               bar_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [IDX_W-1:0]   bar_index,
  output logic [LEVEL_W-1:0] level,
  output logic [PIX_W-1:0]   bar_height,
  output logic [PIX_W-1:0]   peak_row,
  output logic               peak_visible
);

  cfg_t             cfg;
  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [MAG_W-1:0] q_wdata;
  logic [MAG_W-1:0] q_rdata;
  logic             back_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bar_count         <= BAR_COUNT_RST;
      cfg.plot_height       <= PLOT_HEIGHT_RST;
      cfg.hold_frames       <= HOLD_FRAMES_RST;
      cfg.decay_step        <= DECAY_STEP_RST;
      cfg.visible_threshold <= VIS_THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BAR_COUNT:   cfg.bar_count         <= cfg_wdata[7:0];
        REG_PLOT_HEIGHT: cfg.plot_height       <= cfg_wdata[PIX_W-1:0];
        REG_HOLD_FRAMES: cfg.hold_frames       <= cfg_wdata[TIMER_W-1:0];
        REG_DECAY_STEP:  cfg.decay_step        <= cfg_wdata[LEVEL_W-1:0];
        REG_VIS_THRESH:  cfg.visible_threshold <= cfg_wdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  spbpm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .magnitude (magnitude),
    .bar_end   (bar_end),
    .back_busy (back_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  spbpm_fifo #(
    .WIDTH (MAG_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  spbpm_back #(
    .MAX_BARS       (MAX_BARS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_data       (q_rdata),
    .q_pop        (q_pop),
    .busy         (back_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bar_index    (bar_index),
    .level        (level),
    .bar_height   (bar_height),
    .peak_row     (peak_row),
    .peak_visible (peak_visible)
  );

endmodule
